FILE: rtl/msq_pkg.sv
// Shared types, register codes and case tables of the marching-squares segment extractor.
// No dependencies; every other file of the block imports this package.
package msq_pkg;

  // Doubled grid coordinate as it leaves the block.
  typedef logic signed [10:0] coord_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] GRID_COLS_RESET = 9'd16;
  localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RESET = 9'd16;

  // Edge midpoints of one cell.
  typedef enum logic [1:0] {MID_T, MID_B, MID_L, MID_R} mid_t;

  typedef struct packed {
    mid_t f0;
    mid_t t0;
    mid_t f1;
    mid_t t1;
  } tags_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Work handed from the tile stage to the emitter: the corner masks of the four
  // cells a tile can complete (all zero where the cell does not exist) and their origins.
  typedef struct packed {
    logic [3:0][3:0] mask;
    coord_t          gx0;
    coord_t          gy0;
    coord_t          gx_last;
    logic            grid_end;
  } job_t;

  // Number of segments per corner mask (bits TL=0, TR=1, BR=2, BL=3).
  function automatic logic [1:0] case_count(input logic [3:0] mask);
    logic [1:0] n;
    case (mask)
      4'd0, 4'd15: n = 2'd0;
      4'd5, 4'd10: n = 2'd2;
      default:     n = 2'd1;
    endcase
    return n;
  endfunction

  // Oriented segments per corner mask; occupied corners lie on the left of travel.
  function automatic tags_t case_tags(input logic [3:0] mask);
    tags_t t;
    case (mask)
      4'd1:    t = '{MID_L, MID_T, MID_T, MID_T};
      4'd2:    t = '{MID_T, MID_R, MID_T, MID_T};
      4'd3:    t = '{MID_L, MID_R, MID_T, MID_T};
      4'd4:    t = '{MID_R, MID_B, MID_T, MID_T};
      4'd5:    t = '{MID_L, MID_T, MID_R, MID_B};
      4'd6:    t = '{MID_T, MID_B, MID_T, MID_T};
      4'd7:    t = '{MID_L, MID_B, MID_T, MID_T};
      4'd8:    t = '{MID_B, MID_L, MID_T, MID_T};
      4'd9:    t = '{MID_B, MID_T, MID_T, MID_T};
      4'd10:   t = '{MID_T, MID_R, MID_B, MID_L};
      4'd11:   t = '{MID_B, MID_R, MID_T, MID_T};
      4'd12:   t = '{MID_R, MID_L, MID_T, MID_T};
      4'd13:   t = '{MID_R, MID_T, MID_T, MID_T};
      4'd14:   t = '{MID_T, MID_L, MID_T, MID_T};
      default: t = '{MID_T, MID_T, MID_T, MID_T};
    endcase
    return t;
  endfunction

  // Doubled coordinates of an edge midpoint of cell (gx, gy), wrapping at 11 bits.
  function automatic point_t mid_point(input coord_t gx, input coord_t gy, input mid_t tag);
    coord_t x2;
    coord_t y2;
    point_t p;
    x2 = {gx[9:0], 1'b0};
    y2 = {gy[9:0], 1'b0};
    case (tag)
      MID_T: begin
        p.x = x2 + 11'sd1;
        p.y = y2;
      end
      MID_B: begin
        p.x = x2 + 11'sd1;
        p.y = y2 + 11'sd2;
      end
      MID_L: begin
        p.x = x2;
        p.y = y2 + 11'sd1;
      end
      default: begin
        p.x = x2 + 11'sd2;
        p.y = y2 + 11'sd1;
      end
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/msq_stream_if.sv
// Valid/ready channel interfaces of the marching-squares block: tiles in, segments out.
// Depends on msq_pkg for the coordinate type.
interface msq_tile_if;
  logic valid;
  logic ready;
  logic occupied;

  modport source (output valid, output occupied, input ready);
  modport sink (input valid, input occupied, output ready);
endinterface

interface msq_seg_if;
  import msq_pkg::*;
  logic   valid;
  logic   ready;
  coord_t from_x;
  coord_t from_y;
  coord_t to_x;
  coord_t to_y;
  logic   last_of_tile;
  logic   end_of_grid;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  output last_of_tile, output end_of_grid, input ready);
  modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                input last_of_tile, input end_of_grid, output ready);
endinterface

FILE: rtl/msq_emit.sv
// Segment emitter: walks the cells of one tile's job and sends one segment per cycle
// through an output register while it is not stalled. Depends on msq_pkg and msq_seg_if.
module msq_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  msq_pkg::job_t job,
  output logic          job_ready,
  msq_seg_if.source     out_seg
);
  import msq_pkg::*;

  job_t       job_r;
  logic [3:0] pend_r;
  logic       seg_r;
  logic       out_valid_r;
  coord_t     from_x_r, from_y_r, to_x_r, to_y_r;
  logic       last_r, end_r;

  logic [1:0] sel;
  logic [3:0] cur_mask;
  tags_t      tags;
  coord_t     gx, gy;
  point_t     p_from, p_to;
  logic       last_in_cell, last_seg, emit_go;
  logic [3:0] rest, new_pend;

  // Pick the first cell that still has segments and form its next segment.
  always_comb begin
    if (pend_r[0]) sel = 2'd0;
    else if (pend_r[1]) sel = 2'd1;
    else if (pend_r[2]) sel = 2'd2;
    else sel = 2'd3;
    cur_mask     = job_r.mask[sel];
    tags         = case_tags(cur_mask);
    gx           = sel[0] ? job_r.gx_last : job_r.gx0;
    gy           = sel[1] ? (job_r.gy0 + 11'sd1) : job_r.gy0;
    p_from       = mid_point(gx, gy, seg_r ? tags.f1 : tags.f0);
    p_to         = mid_point(gx, gy, seg_r ? tags.t1 : tags.t0);
    last_in_cell = seg_r || (case_count(cur_mask) == 2'd1);
    rest         = pend_r & ~(4'b0001 << sel);
    last_seg     = last_in_cell && (rest == 4'b0000);
    emit_go      = (pend_r != 4'b0000) && (!out_valid_r || out_seg.ready);
    job_ready    = (pend_r == 4'b0000) || (emit_go && last_seg);
    for (int k = 0; k < 4; k++) begin
      new_pend[k] = (case_count(job.mask[k]) != 2'd0);
    end
  end

  // Control: pending cells, segment index within the cell, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 4'b0000;
      seg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_seg.ready) begin
        out_valid_r <= 1'b0;
      end
      if (job_valid && job_ready) begin
        pend_r <= new_pend;
        seg_r  <= 1'b0;
      end else if (emit_go) begin
        if (last_in_cell) begin
          pend_r <= rest;
          seg_r  <= 1'b0;
        end else begin
          seg_r <= 1'b1;
        end
      end
    end
  end

  // Payload: job and output register.
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (emit_go) begin
      from_x_r <= p_from.x;
      from_y_r <= p_from.y;
      to_x_r   <= p_to.x;
      to_y_r   <= p_to.y;
      last_r   <= last_seg;
      end_r    <= last_seg && job_r.grid_end;
    end
  end

  assign out_seg.valid        = out_valid_r;
  assign out_seg.from_x       = from_x_r;
  assign out_seg.from_y       = from_y_r;
  assign out_seg.to_x         = to_x_r;
  assign out_seg.to_y         = to_y_r;
  assign out_seg.last_of_tile = last_r;
  assign out_seg.end_of_grid  = end_r;

endmodule

FILE: rtl/marching_squares_segments.sv
// Streaming marching-squares boundary extractor: top level with line store and tile stage.
// Depends on msq_pkg, msq_stream_if and msq_emit.

// One occupancy tile is accepted per cycle in raster order unless the tile stage is held.
// The previous row lives in a one-bit-wide synchronous line store of MAX_COLS entries,
// read and rewritten at the tile's column in the cycle the tile is accepted; the stage
// after it builds the four cells a tile can complete. A tile with segments holds the
// emitter until its last is sent, one segment per cycle into the output register while
// it is not stalled; a tile with none passes straight on. A tile's first segment passes
// the tile stage, the emitter's job register and the output register. The line store is
// never cleared: row 0 ignores what it reads, and every later row reads only what the row
// before wrote. Writing grid_cols or grid_rows restarts the grid at tile (0,0); a value
// of 0 acts as 1 and a value above MAX_COLS or MAX_ROWS acts as that maximum.
module marching_squares_segments #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  msq_tile_if.sink                         in_tile,
  msq_seg_if.source                        out_seg
);
  import msq_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CFG_DATA_W-1:0] cfg_cols_r, cfg_rows_r;
  logic [CW:0]           cols_eff;
  logic [RW:0]           rows_eff;

  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic          left_cur_r;
  logic          la_r;

  logic          line_mem [MAX_COLS];
  logic          above_rd_r;

  logic          s1_valid_r, s1_cur_r, s1_left_r, s1_lc_r, s1_lr_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;

  logic last_col, last_row, in_go, s1_adv, above, job_ready, cfg_hit;
  job_t job;

  // Grid size as used, clamped into 1..MAX.
  always_comb begin
    if (cfg_cols_r == '0) cols_eff = (CW+1)'(1);
    else if (32'(cfg_cols_r) > MAX_COLS) cols_eff = (CW+1)'(MAX_COLS);
    else cols_eff = (CW+1)'(cfg_cols_r);
    if (cfg_rows_r == '0) rows_eff = (RW+1)'(1);
    else if (32'(cfg_rows_r) > MAX_ROWS) rows_eff = (RW+1)'(MAX_ROWS);
    else rows_eff = (RW+1)'(cfg_rows_r);
  end

  assign last_col  = (({1'b0, col_cnt_r} + (CW+1)'(1)) == cols_eff);
  assign last_row  = (({1'b0, row_cnt_r} + (RW+1)'(1)) == rows_eff);
  assign s1_adv    = s1_valid_r && job_ready;
  assign in_tile.ready = !s1_valid_r || s1_adv;
  assign in_go     = in_tile.valid && in_tile.ready;
  assign cfg_hit   = cfg_we && ((cfg_index == REG_GRID_COLS) || (cfg_index == REG_GRID_ROWS));

  // Configuration registers, position counters and left neighbors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= GRID_COLS_RESET;
      cfg_rows_r <= GRID_ROWS_RESET;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      left_cur_r <= 1'b0;
      la_r       <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_GRID_COLS)) cfg_cols_r <= cfg_wdata;
      if (cfg_we && (cfg_index == REG_GRID_ROWS)) cfg_rows_r <= cfg_wdata;
      if (cfg_hit) begin
        la_r <= 1'b0;
      end else if (s1_adv) begin
        la_r <= s1_lc_r ? 1'b0 : above;
      end
      if (in_go) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        col_cnt_r  <= '0;
        row_cnt_r  <= '0;
        left_cur_r <= 1'b0;
      end else if (in_go) begin
        if (last_col) begin
          col_cnt_r  <= '0;
          row_cnt_r  <= last_row ? '0 : row_cnt_r + RW'(1);
          left_cur_r <= 1'b0;
        end else begin
          col_cnt_r  <= col_cnt_r + CW'(1);
          left_cur_r <= in_tile.occupied;
        end
      end
    end
  end

  // Line store: read the tile above and write the new tile at the same column.
  always_ff @(posedge clk) begin
    if (in_go) begin
      above_rd_r         <= line_mem[col_cnt_r];
      line_mem[col_cnt_r] <= in_tile.occupied;
    end
  end

  // Tile stage payload.
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_cur_r  <= in_tile.occupied;
      s1_left_r <= left_cur_r;
      s1_col_r  <= col_cnt_r;
      s1_row_r  <= row_cnt_r;
      s1_lc_r   <= last_col;
      s1_lr_r   <= last_row;
    end
  end

  // Corner masks (TL=bit 0, TR=1, BR=2, BL=3) of the cells this tile completes.
  always_comb begin
    above        = (s1_row_r != '0) && above_rd_r;
    job.mask[0]  = {s1_left_r, s1_cur_r, above, la_r};
    job.mask[1]  = s1_lc_r ? {s1_cur_r, 2'b00, above} : 4'b0000;
    job.mask[2]  = s1_lr_r ? {2'b00, s1_cur_r, s1_left_r} : 4'b0000;
    job.mask[3]  = (s1_lc_r && s1_lr_r) ? {3'b000, s1_cur_r} : 4'b0000;
    job.gx0      = 11'(s1_col_r) - 11'sd1;
    job.gy0      = 11'(s1_row_r) - 11'sd1;
    job.gx_last  = 11'(cols_eff) - 11'sd1;
    job.grid_end = s1_lc_r && s1_lr_r;
  end

  msq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (s1_valid_r),
    .job       (job),
    .job_ready (job_ready),
    .out_seg   (out_seg)
  );

`ifndef NO_ASSERTIONS
  // The position counters never leave the grid.
  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_cnt_r} < cols_eff))
    else $error("column counter outside the grid");

  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_cnt_r} < rows_eff))
    else $error("row counter outside the grid");

  // The end of the grid is always the last segment of its tile.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_seg.valid && out_seg.end_of_grid) |-> out_seg.last_of_tile)
    else $error("end_of_grid without last_of_tile");
`endif

endmodule

FILE: sim/marching_squares_segments_tb.sv
// Self-checking testbench for the marching-squares segment extractor.
// Drives tiles and register writes, predicts every segment and checks the result stream.
// Depends on msq_pkg, msq_stream_if and the marching_squares_segments RTL.
module marching_squares_segments_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msq_pkg::*;

  localparam int GRID_MAX          = 256;
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int SETTLE_CYCLES     = 12;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int SMALL_TILE_TARGET = 160;
  localparam int MAX_REPORTS       = 10;

  // Register indexes past the end of the register list; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    logic   last_of_tile;
    logic   end_of_grid;
  } segment_t;

  typedef enum logic {ROW_CFG, ROW_TILE} row_kind_t;

  // One line of the directed table: a register write or a tile, with optional typed results.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    logic                 occupied;
    logic                 use_lit;
    logic [2:0]           n_lit;
    segment_t [3:0]       lit;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  msq_tile_if tile_bus ();
  msq_seg_if  seg_bus ();

  marching_squares_segments uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tile   (tile_bus.sink),
    .out_seg   (seg_bus.source)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's registers and raster state.
  logic [CFG_DATA_W-1:0] shadow_cols;
  logic [CFG_DATA_W-1:0] shadow_rows;
  logic                  shadow_line [GRID_MAX];
  int unsigned           shadow_col;
  int unsigned           shadow_row;
  logic                  shadow_left;
  logic                  shadow_left_above;

  segment_t      tile_segments[$];
  segment_t      expected_segments[$];
  directed_row_t directed[$];

  int  failures;
  int  tiles_sent;
  int  segments_checked;
  int  writes_done;
  int  cycle_count;
  bit  no_gaps;
  bit  hold_request;

  function automatic segment_t seg(input int fx, input int fy, input int tx, input int ty,
                                   input logic last, input logic eog);
    segment_t s;
    s.from_x       = fx[10:0];
    s.from_y       = fy[10:0];
    s.to_x         = tx[10:0];
    s.to_y         = ty[10:0];
    s.last_of_tile = last;
    s.end_of_grid  = eog;
    return s;
  endfunction

  function automatic int unsigned grid_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return 32'(v);
  endfunction

  // Oriented contour segments per corner mask (TL bit 0, TR bit 1, BR bit 2, BL bit 3).
  // Occupied corners sit on the left of travel; saddles give two separate segments.
  function automatic void cell_table(input logic [3:0] mask, output int n, output tags_t e);
    n = (mask == 4'd0 || mask == 4'd15) ? 0 : (mask == 4'd5 || mask == 4'd10) ? 2 : 1;
    case (mask)
      4'd1:    e = '{MID_L, MID_T, MID_T, MID_T};
      4'd2:    e = '{MID_T, MID_R, MID_T, MID_T};
      4'd3:    e = '{MID_L, MID_R, MID_T, MID_T};
      4'd4:    e = '{MID_R, MID_B, MID_T, MID_T};
      4'd5:    e = '{MID_L, MID_T, MID_R, MID_B};
      4'd6:    e = '{MID_T, MID_B, MID_T, MID_T};
      4'd7:    e = '{MID_L, MID_B, MID_T, MID_T};
      4'd8:    e = '{MID_B, MID_L, MID_T, MID_T};
      4'd9:    e = '{MID_B, MID_T, MID_T, MID_T};
      4'd10:   e = '{MID_T, MID_R, MID_B, MID_L};
      4'd11:   e = '{MID_B, MID_R, MID_T, MID_T};
      4'd12:   e = '{MID_R, MID_L, MID_T, MID_T};
      4'd13:   e = '{MID_R, MID_T, MID_T, MID_T};
      4'd14:   e = '{MID_T, MID_L, MID_T, MID_T};
      default: e = '{MID_T, MID_T, MID_T, MID_T};
    endcase
  endfunction

  // Edge midpoint of cell (gx, gy) in doubled coordinates, y growing downward.
  function automatic void edge_point(input int gx, input int gy, input mid_t tag,
                                     output int x, output int y);
    case (tag)
      MID_T: begin
        x = 2 * gx + 1;
        y = 2 * gy;
      end
      MID_B: begin
        x = 2 * gx + 1;
        y = 2 * gy + 2;
      end
      MID_L: begin
        x = 2 * gx;
        y = 2 * gy + 1;
      end
      default: begin
        x = 2 * gx + 2;
        y = 2 * gy + 1;
      end
    endcase
  endfunction

  function automatic void add_cell(input int gx, input int gy, input logic [3:0] mask);
    int    n;
    tags_t e;
    int    x0, y0, x1, y1;
    cell_table(mask, n, e);
    if (n >= 1) begin
      edge_point(gx, gy, e.f0, x0, y0);
      edge_point(gx, gy, e.t0, x1, y1);
      tile_segments.insert(tile_segments.size(), seg(x0, y0, x1, y1, 1'b0, 1'b0));
    end
    if (n == 2) begin
      edge_point(gx, gy, e.f1, x0, y0);
      edge_point(gx, gy, e.t1, x1, y1);
      tile_segments.insert(tile_segments.size(), seg(x0, y0, x1, y1, 1'b0, 1'b0));
    end
  endfunction

  function automatic void restart_raster();
    shadow_col        = 0;
    shadow_row        = 0;
    shadow_left       = 1'b0;
    shadow_left_above = 1'b0;
  endfunction

  // Segments that one tile completes, in emission order, into tile_segments.
  function automatic void predict_segments(input logic occ);
    int unsigned cols, rows, c, r;
    logic        last_c, last_r, above, left, left_above;
    cols = grid_dim(shadow_cols);
    rows = grid_dim(shadow_rows);
    c = shadow_col;
    r = shadow_row;
    tile_segments.delete();
    if (c >= cols || r >= rows) begin
      c = 0;
      r = 0;
    end
    last_c     = (c + 1 == cols);
    last_r     = (r + 1 == rows);
    above      = (r > 0) ? shadow_line[c] : 1'b0;
    left       = (c > 0) ? shadow_left : 1'b0;
    left_above = (c > 0 && r > 0) ? shadow_left_above : 1'b0;

    add_cell(int'(c) - 1, int'(r) - 1, {left, occ, above, left_above});
    if (last_c) add_cell(int'(cols) - 1, int'(r) - 1, {occ, 1'b0, 1'b0, above});
    if (last_r) add_cell(int'(c) - 1, int'(r), {1'b0, 1'b0, occ, left});
    if (last_c && last_r) add_cell(int'(cols) - 1, int'(r), {3'b000, occ});
    if (tile_segments.size() > 0) begin
      tile_segments[$].last_of_tile = 1'b1;
      tile_segments[$].end_of_grid  = last_c && last_r;
    end

    shadow_line[c]    = occ;
    shadow_left       = occ;
    shadow_left_above = above;
    if (last_c) begin
      restart_raster();
      shadow_row = last_r ? 0 : r + 1;
    end else begin
      shadow_col = c + 1;
      shadow_row = r;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data, input logic occ,
                                  input logic use_lit, input int n_lit,
                                  input segment_t [3:0] lit);
    directed_row_t row;
    row.kind     = kind;
    row.index    = idx;
    row.data     = data;
    row.occupied = occ;
    row.use_lit  = use_lit;
    row.n_lit    = n_lit[2:0];
    row.lit      = lit;
    directed.insert(directed.size(), row);
  endfunction

  // Directed table: reset default, degenerate and saturated sizes, ignored indexes,
  // a restart in the middle of a grid and a saddle.
  function automatic void build_directed();
    segment_t [3:0] corner;
    segment_t [3:0] square;
    corner    = '0;
    corner[0] = seg(0, -1, -1, 0, 1'b1, 1'b0);
    square[0] = seg(0, -1, -1, 0, 1'b0, 1'b0);
    square[1] = seg(1, 0, 0, -1, 1'b0, 1'b0);
    square[2] = seg(-1, 0, 0, 1, 1'b0, 1'b0);
    square[3] = seg(0, 1, 1, 0, 1'b1, 1'b1);

    // Tile (0,0) of the 16x16 reset grid only closes its top-left corner cell.
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b1, 1, corner);
    // Zero sizes act as a 1x1 grid: a lone tile is a closed square, an empty one is quiet.
    add_row(ROW_CFG, REG_GRID_COLS, 9'd0, 1'b0, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_GRID_ROWS, 9'd0, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b1, 4, square);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b0, 1'b1, 0, '0);
    // Writes to spare indexes in the middle of a 2x1 grid must not restart it.
    add_row(ROW_CFG, REG_GRID_COLS, 9'd2, 1'b0, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_GRID_ROWS, 9'd1, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_SPARE_2, 9'h1FF, 1'b0, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_SPARE_3, 9'h000, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b0, 1'b0, 0, '0);
    // 2x2 grid with a diagonal pair: the saddle cell between them gives two segments.
    add_row(ROW_CFG, REG_GRID_COLS, 9'd2, 1'b0, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_GRID_ROWS, 9'd2, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
    // Half a grid, then a rewrite of the same value restarts at tile (0,0).
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_GRID_ROWS, 9'd2, 1'b0, 1'b0, 0, '0);
    repeat (4) add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
    // Sizes above the maximum saturate.
    add_row(ROW_CFG, REG_GRID_COLS, 9'h1FF, 1'b0, 1'b0, 0, '0);
    add_row(ROW_CFG, REG_GRID_ROWS, 9'h1FF, 1'b0, 1'b0, 0, '0);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b1, 1, corner);
    add_row(ROW_TILE, REG_GRID_COLS, '0, 1'b1, 1'b0, 0, '0);
  endfunction

  // Offer one tile until the block takes it, then queue what it should produce.
  task automatic send_tile(input logic occ, input logic use_lit, input int n_lit,
                           input segment_t [3:0] lit);
    int gap;
    tile_bus.valid    <= 1'b1;
    tile_bus.occupied <= occ;
    @(posedge clk);
    while (!tile_bus.ready) @(posedge clk);
    predict_segments(occ);
    if (use_lit) begin
      for (int k = 0; k < n_lit; k++)
        expected_segments.insert(expected_segments.size(), lit[k]);
    end else begin
      foreach (tile_segments[k])
        expected_segments.insert(expected_segments.size(), tile_segments[k]);
    end
    tiles_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      tile_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write; the enable stays high when another write follows directly.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input bit more);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GRID_COLS: begin
        shadow_cols = value;
        restart_raster();
      end
      REG_GRID_ROWS: begin
        shadow_rows = value;
        restart_raster();
      end
      default: ;
    endcase
    writes_done++;
    if (!more) cfg_we <= 1'b0;
  endtask

  // Stop offering tiles and let every pending segment drain out of the block.
  task automatic wait_idle();
    tile_bus.valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: runs of ready and stall of random length, plus one long hold-off on request.
  initial begin : seg_receiver
    int   run_left;
    int   hold_left;
    int   r;
    logic run_level;
    seg_bus.ready = 1'b0;
    run_left  = 0;
    hold_left = 0;
    run_level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        seg_bus.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            run_level = 1'b1;
            run_left  = $urandom_range(1, 6);
          end else if (r < 85) begin
            run_level = 1'b0;
            run_left  = $urandom_range(1, 3);
          end else if (r < 95) begin
            run_level = 1'b1;
            run_left  = $urandom_range(40, 120);
          end else begin
            run_level = 1'b0;
            run_left  = $urandom_range(10, 30);
          end
        end
        run_left--;
        seg_bus.ready <= run_level;
      end
    end
  end

  // Each segment transaction is checked against the oldest expected segment.
  always @(posedge clk) begin : seg_monitor
    segment_t got;
    segment_t want;
    if (rst_n === 1'b1 && seg_bus.valid === 1'b1 && seg_bus.ready === 1'b1) begin
      got.from_x       = seg_bus.from_x;
      got.from_y       = seg_bus.from_y;
      got.to_x         = seg_bus.to_x;
      got.to_y         = seg_bus.to_y;
      got.last_of_tile = seg_bus.last_of_tile;
      got.end_of_grid  = seg_bus.end_of_grid;
      if (expected_segments.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected segment (%0d,%0d)->(%0d,%0d) last %0b end %0b",
                   got.from_x, got.from_y, got.to_x, got.to_y,
                   got.last_of_tile, got.end_of_grid);
      end else begin
        want = expected_segments.pop_front();
        segments_checked++;
        if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
            got.to_x !== want.to_x || got.to_y !== want.to_y ||
            got.last_of_tile !== want.last_of_tile ||
            got.end_of_grid !== want.end_of_grid) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("segment %0d: got (%0d,%0d)->(%0d,%0d) last %0b end %0b",
                     segments_checked, got.from_x, got.from_y, got.to_x, got.to_y,
                     got.last_of_tile, got.end_of_grid);
            $display("  expected (%0d,%0d)->(%0d,%0d) last %0b end %0b",
                     want.from_x, want.from_y, want.to_x, want.to_y,
                     want.last_of_tile, want.end_of_grid);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments still expected",
               cycle_count, expected_segments.size());
      $display("FAIL marching_squares_segments");
      $finish;
    end
  end

  // Stimulus: directed table, small random grids, then the widest row and the start of the tallest column.
  initial begin : stimulus
    int unsigned cols_v;
    int unsigned rows_v;
    int unsigned grid_tiles;
    int          n_tiles;
    int          fill;
    int          pick;
    int          small_tiles;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_GRID_COLS;
    cfg_wdata         = '0;
    tile_bus.valid    = 1'b0;
    tile_bus.occupied = 1'b0;
    failures          = 0;
    tiles_sent        = 0;
    segments_checked  = 0;
    writes_done       = 0;
    cycle_count       = 0;
    no_gaps           = 1'b0;
    hold_request      = 1'b0;
    small_tiles       = 0;

    shadow_cols = GRID_COLS_RESET;
    shadow_rows = GRID_ROWS_RESET;
    foreach (shadow_line[i]) shadow_line[i] = 1'b0;
    restart_raster();
    build_directed();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; a run of register writes waits until the block is idle.
    for (int i = 0; i < directed.size(); i++) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i-1].kind != ROW_CFG) wait_idle();
        write_reg(directed[i].index, directed[i].data,
                  (i + 1 < directed.size()) && (directed[i+1].kind == ROW_CFG));
      end else begin
        send_tile(directed[i].occupied, directed[i].use_lit, directed[i].n_lit,
                  directed[i].lit);
      end
    end

    // Small grids of random size and density; some are cut short by a rewrite.
    while (small_tiles < SMALL_TILE_TARGET) begin
      wait_idle();
      cols_v = $urandom_range(0, 8);
      rows_v = $urandom_range(0, 6);
      pick   = $urandom_range(0, 3);
      if (pick != 1) write_reg(REG_GRID_COLS, cols_v[8:0], pick != 2);
      if (pick != 2) write_reg(REG_GRID_ROWS, rows_v[8:0], 1'b0);
      grid_tiles = grid_dim(shadow_cols) * grid_dim(shadow_rows);
      pick = $urandom_range(0, 4);
      if (pick == 0) n_tiles = $urandom_range(1, grid_tiles);
      else if (pick == 1) n_tiles = 2 * grid_tiles;
      else n_tiles = grid_tiles;
      fill    = $urandom_range(0, 100);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (n_tiles) send_tile($urandom_range(0, 99) < fill, 1'b0, 0, '0);
      small_tiles += n_tiles;
    end
    no_gaps = 1'b0;

    // One full row of the widest grid, sent back to back against a long receiver hold-off.
    wait_idle();
    write_reg(REG_GRID_COLS, 9'd256, 1'b1);
    write_reg(REG_GRID_ROWS, 9'd1, 1'b0);
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    fill         = $urandom_range(30, 70);
    repeat (256) send_tile($urandom_range(0, 99) < fill, 1'b0, 0, '0);
    no_gaps = 1'b0;

    // The sender pauses until everything has drained, then starts the tallest grid.
    wait_idle();
    write_reg(REG_GRID_ROWS, 9'h1FF, 1'b1);
    write_reg(REG_GRID_COLS, 9'd1, 1'b0);
    repeat (24) send_tile(1'($urandom_range(0, 1)), 1'b0, 0, '0);

    wait_idle();
    $display("run covered %0d tiles and %0d register writes over directed and random grids",
             tiles_sent, writes_done);
    $display("%0d segments checked, %0d mismatches", segments_checked, failures);
    if (failures == 0 && expected_segments.size() == 0) begin
      $display("PASS marching_squares_segments");
    end else begin
      $display("FAIL marching_squares_segments");
    end
    $finish;
  end

endmodule
